// ===== sv/fslh_pkg.sv =====
package fslh_pkg;

   localparam int unsigned LenWidth = 12;

   localparam logic [63:0] FNV_OFFSET     = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME_LOW  = 64'h00000000000001b3;
   localparam int unsigned FNV_PRIME_HIGH = 40;
   localparam logic [63:0] MIX_MUL_A      = 64'h7fb5d329728ea185;
   localparam logic [63:0] MIX_MUL_B      = 64'h81dadef4bc2dd44d;
   localparam logic [63:0] NULL_HASH      = 64'h8000000000000000;
   localparam logic [LenWidth-1:0] SHORT_LIMIT = 12'd8;
   localparam logic [LenWidth-1:0] LEN_RESET   = 12'd8;

   localparam int unsigned MIX_SHIFT_1 = 31;
   localparam int unsigned MIX_SHIFT_2 = 27;
   localparam int unsigned MIX_SHIFT_3 = 33;

   typedef enum logic [2:0] {
      MIX_IDLE,
      MIX_STEP_A,
      MIX_PREP_B,
      MIX_STEP_B,
      MIX_FINISH
   } mix_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mix_status_type;

endpackage

// ===== sv/fslh_mul.sv =====
// One multiply-accumulate step: acc + ((x * chunk) << 16*idx), low 64 bits.
module fslh_mul (
   input  logic [63:0] x,
   input  logic [15:0] chunk,
   input  logic [1:0]  idx,
   input  logic [63:0] acc,
   output logic [63:0] sum
);

   logic [63:0] prod;
   logic [63:0] shifted;

   assign prod    = x * {48'b0, chunk};
   assign shifted = prod << {idx, 4'b0000};
   assign sum     = acc + shifted;

endmodule

// ===== sv/fslh_mix.sv =====
// 64-bit finalizer, sequenced over the shared 64x16 multiply step.
module fslh_mix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [63:0]             value,
   output fslh_pkg::mix_status_type status,
   output logic [63:0]             result
);

   fslh_pkg::mix_state_type state_ff, state_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic [15:0] chunk;
   logic [63:0] mul_sum;

   fslh_mul u_mul (
      .x     (x_ff),
      .chunk (chunk),
      .idx   (step_ff),
      .acc   (acc_ff),
      .sum   (mul_sum)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fslh_pkg::MIX_IDLE: begin
            if (start) state_in = fslh_pkg::MIX_STEP_A;
         end
         fslh_pkg::MIX_STEP_A: begin
            if (step_ff == 2'd3) state_in = fslh_pkg::MIX_PREP_B;
         end
         fslh_pkg::MIX_PREP_B: state_in = fslh_pkg::MIX_STEP_B;
         fslh_pkg::MIX_STEP_B: begin
            if (step_ff == 2'd3) state_in = fslh_pkg::MIX_FINISH;
         end
         fslh_pkg::MIX_FINISH: state_in = fslh_pkg::MIX_IDLE;
         default: state_in = fslh_pkg::MIX_IDLE;
      endcase
   end

   always_comb begin
      x_in        = x_ff;
      acc_in      = acc_ff;
      step_in     = step_ff;
      chunk       = 16'b0;
      status.busy = 1'b1;
      status.done = 1'b0;
      result      = acc_ff ^ (acc_ff >> fslh_pkg::MIX_SHIFT_3);
      unique case (state_ff)
         fslh_pkg::MIX_IDLE: begin
            status.busy = 1'b0;
            x_in        = value ^ (value >> fslh_pkg::MIX_SHIFT_1);
            acc_in      = 64'b0;
            step_in     = 2'd0;
         end
         fslh_pkg::MIX_STEP_A: begin
            chunk   = fslh_pkg::MIX_MUL_A[{step_ff, 4'b0000} +: 16];
            acc_in  = mul_sum;
            step_in = step_ff + 2'd1;
         end
         fslh_pkg::MIX_PREP_B: begin
            x_in    = acc_ff ^ (acc_ff >> fslh_pkg::MIX_SHIFT_2);
            acc_in  = 64'b0;
            step_in = 2'd0;
         end
         fslh_pkg::MIX_STEP_B: begin
            chunk   = fslh_pkg::MIX_MUL_B[{step_ff, 4'b0000} +: 16];
            acc_in  = mul_sum;
            step_in = step_ff + 2'd1;
         end
         fslh_pkg::MIX_FINISH: status.done = 1'b1;
         default: status.busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fslh_pkg::MIX_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

endmodule

// ===== sv/fixed_length_string_hash.sv =====
// Byte words are taken one per cycle while the finalizer is idle and no result is stalled.
// Null strings and long (FNV-1a) strings: hash in the output register in the cycle after
// the completing word. Short strings (length <= 8): the finalizer runs 2 x 4 steps plus
// prep and finish on the shared 64x16 multiply unit; result at finish; req_tready low.
// Synchronous active-high reset: length 8, string state cleared, no result pending.
module fixed_length_string_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tuser,   // [0] string_is_null
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] hash_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data     // [11:0] string_length
);

   function automatic logic [63:0] fnv_mul(input logic [63:0] x);
      return (x * fslh_pkg::FNV_PRIME_LOW) + (x << fslh_pkg::FNV_PRIME_HIGH);
   endfunction

   logic [fslh_pkg::LenWidth-1:0] length_ff;
   logic [fslh_pkg::LenWidth-1:0] count_ff, count_in;
   logic [63:0] acc_ff, acc_in;
   logic        stopped_ff, stopped_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        short_mode;
   logic        first;
   logic [63:0] acc_base;
   logic        stopped_base;
   logic        str_done;
   logic        mix_start;
   fslh_pkg::mix_status_type mix_status;
   logic [63:0] mix_result;

   fslh_mix u_mix (
      .clock  (clock),
      .reset  (reset),
      .start  (mix_start),
      .value  (acc_in),
      .status (mix_status),
      .result (mix_result)
   );

   assign req_tready = !mix_status.busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign short_mode   = length_ff <= fslh_pkg::SHORT_LIMIT;
   assign first        = count_ff == '0;
   assign acc_base     = first ? (short_mode ? 64'b0 : fslh_pkg::FNV_OFFSET) : acc_ff;
   assign stopped_base = first ? 1'b0 : stopped_ff;

   always_comb begin
      acc_in     = acc_base;
      stopped_in = stopped_base;
      if (short_mode) begin
         acc_in = {acc_base[55:0], req_tdata};
      end else if (!stopped_base) begin
         if (req_tdata == 8'h00) begin
            stopped_in = 1'b1;
         end else begin
            acc_in = fnv_mul(acc_base ^ {56'b0, req_tdata});
         end
      end
      count_in = count_ff + 12'd1;
   end

   // count_in >= 0 is always true, so a zero length completes on the first byte
   assign str_done  = count_in >= length_ff;
   assign mix_start = accept && !req_tuser && str_done && short_mode;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (mix_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = mix_result;
      end else if (accept && req_tuser) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fslh_pkg::NULL_HASH;
      end else if (accept && str_done && !short_mode) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = acc_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= fslh_pkg::LEN_RESET;
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
         acc_ff       <= 64'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            length_ff  <= csr_data;
            count_ff   <= '0;
            stopped_ff <= 1'b0;
            acc_ff     <= 64'b0;
         end else if (accept) begin
            if (req_tuser || str_done) begin
               count_ff   <= '0;
               stopped_ff <= 1'b0;
               acc_ff     <= 64'b0;
            end else begin
               count_ff   <= count_in;
               stopped_ff <= stopped_in;
               acc_ff     <= acc_in;
            end
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== sv/fslh_check.sv =====
module fslh_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // pending result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending right after reset");

   a_null_hash: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser
      |=> rsp_tvalid && rsp_tdata == fslh_pkg::NULL_HASH)
      else $error("null string did not give its hash in the next cycle");

   // no byte may be taken while a result word is blocked
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output word stalled");

endmodule

bind fixed_length_string_hash fslh_check u_check (.*);
